[rtl/core/uart_rx_fifo_error_counters_core_assert.svh]
// assertion macros for the serial receive fifo core
`ifndef UART_RX_FIFO_ERROR_COUNTERS_CORE_ASSERT_SVH
`define UART_RX_FIFO_ERROR_COUNTERS_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define URFEC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define URFEC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, always on
`define URFEC_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/urfec_pkg.sv]
// shared widths and defaults for the serial receive fifo core
`default_nettype none

package urfec_pkg;

  localparam int unsigned RING_DEPTH_DEFAULT = 256;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned CTR_W  = 32;

endpackage

`default_nettype wire

[rtl/core/urfec_if.sv]
// request and result channel interfaces of the serial receive fifo core
`default_nettype none

interface urfec_req_if;
  import urfec_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic              parity_flag;
  logic              framing_flag;
  logic              noise_flag;
  logic              overrun_flag;
  logic              data_ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (
    output valid, mode, parity_flag, framing_flag, noise_flag, overrun_flag,
           data_ready, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, mode, parity_flag, framing_flag, noise_flag, overrun_flag,
           data_ready, rx_byte,
    output ready
  );
endinterface

interface urfec_rsp_if;
  import urfec_pkg::*;

  logic              valid;
  logic              ready;
  logic              pop_valid;
  logic [BYTE_W-1:0] pop_byte;
  logic [FILL_W-1:0] fill_count;
  logic [MASK_W-1:0] clear_mask;
  logic [CTR_W-1:0]  parity_errors;
  logic [CTR_W-1:0]  framing_errors;
  logic [CTR_W-1:0]  noise_errors;
  logic [CTR_W-1:0]  overrun_errors;
  logic [CTR_W-1:0]  ring_overflows;

  modport source (
    output valid, pop_valid, pop_byte, fill_count, clear_mask, parity_errors,
           framing_errors, noise_errors, overrun_errors, ring_overflows,
    input  ready
  );

  modport sink (
    input  valid, pop_valid, pop_byte, fill_count, clear_mask, parity_errors,
           framing_errors, noise_errors, overrun_errors, ring_overflows,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/uart_rx_fifo_error_counters_core.sv]
// serial receive fifo with saturating error and overflow counters
//
//   channel | dir | beat
//   --------+-----+-------------------------------------------------------
//   req     | in  | receive event (flags, data_ready, rx_byte) or pop request
//   rsp     | out | pop result, fill count, clear mask and all counters
//
// a receive event or a pop on an empty ring gives its result in the cycle
// after the beat; a pop of a held byte passes through S_READ first, for the
// registered ring read port. one item is in flight at a time; req is taken
// in S_IDLE while the result slot is empty or being drained in the same
// cycle. reset clears pointers, fill count and counters; ring contents stay
// undefined and no clearing pass runs. a stalled rsp holds its beat.
`default_nettype none

module uart_rx_fifo_error_counters_core #(
  parameter int unsigned RING_DEPTH = urfec_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  urfec_req_if.sink   req,
  urfec_rsp_if.source rsp
);
  import urfec_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v,
                                               input logic en);
    return (en && (v != '1)) ? v + 1'b1 : v;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [BYTE_W-1:0] ring [RING_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, tail;
  logic [CNT_W-1:0]  held, held_next;
  logic [CTR_W-1:0]  parity_cnt, framing_cnt, noise_cnt, overrun_cnt, overflow_cnt;
  logic              out_valid;
  logic              pop_valid;
  logic [MASK_W-1:0] clear_mask;

  logic              accept;
  logic              rcv;
  logic              full;
  logic              push_en;
  logic              pop_en;
  logic              drop;
  logic [MASK_W-1:0] flags;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rcv       = accept && !req.mode;
  assign full      = (held == CNT_W'(RING_DEPTH));
  assign push_en   = rcv && req.data_ready && !full;
  assign drop      = rcv && req.data_ready && full;
  assign pop_en    = accept && req.mode && (held != '0);
  assign flags     = {req.overrun_flag, req.noise_flag, req.framing_flag, req.parity_flag}
                     & {MASK_W{rcv}};

  always_comb begin
    held_next = held;
    if (push_en) begin
      held_next = held + CNT_W'(1);
    end else if (pop_en) begin
      held_next = held - CNT_W'(1);
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = pop_en ? S_READ : S_IDLE;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring[head] <= req.rx_byte;
    end
    if (pop_en) begin
      rd_data <= ring[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      held         <= '0;
      parity_cnt   <= '0;
      framing_cnt  <= '0;
      noise_cnt    <= '0;
      overrun_cnt  <= '0;
      overflow_cnt <= '0;
      out_valid    <= 1'b0;
      pop_valid    <= 1'b0;
      clear_mask   <= '0;
    end else begin
      state        <= state_next;
      held         <= held_next;
      parity_cnt   <= sat_inc(parity_cnt, flags[0]);
      framing_cnt  <= sat_inc(framing_cnt, flags[1]);
      noise_cnt    <= sat_inc(noise_cnt, flags[2]);
      overrun_cnt  <= sat_inc(overrun_cnt, flags[3]);
      overflow_cnt <= sat_inc(overflow_cnt, drop);
      if (push_en) begin
        head <= wrap_inc(head);
      end
      if (pop_en) begin
        tail <= wrap_inc(tail);
      end
      if (accept) begin
        pop_valid  <= pop_en;
        clear_mask <= flags;
      end
      if (state == S_READ) begin
        out_valid <= 1'b1;
      end else if (accept) begin
        out_valid <= !pop_en;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // counters and fill count only move on a req beat, with rsp empty or draining
  assign rsp.valid          = out_valid;
  assign rsp.pop_valid      = pop_valid;
  assign rsp.pop_byte       = pop_valid ? rd_data : '0;
  assign rsp.fill_count     = FILL_W'(held);
  assign rsp.clear_mask     = clear_mask;
  assign rsp.parity_errors  = parity_cnt;
  assign rsp.framing_errors = framing_cnt;
  assign rsp.noise_errors   = noise_cnt;
  assign rsp.overrun_errors = overrun_cnt;
  assign rsp.ring_overflows = overflow_cnt;

endmodule

`default_nettype wire

[rtl/core/urfec_checker.sv]
// port-level checks of the serial receive fifo core and their bind
`default_nettype none

`include "uart_rx_fifo_error_counters_core_assert.svh"

module urfec_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       pop_valid,
  input wire logic [urfec_pkg::BYTE_W-1:0] pop_byte,
  input wire logic [urfec_pkg::FILL_W-1:0] fill_count,
  input wire logic [urfec_pkg::MASK_W-1:0] clear_mask,
  input wire logic [urfec_pkg::CTR_W-1:0]  parity_errors,
  input wire logic [urfec_pkg::CTR_W-1:0]  framing_errors,
  input wire logic [urfec_pkg::CTR_W-1:0]  noise_errors,
  input wire logic [urfec_pkg::CTR_W-1:0]  overrun_errors,
  input wire logic [urfec_pkg::CTR_W-1:0]  ring_overflows
);
  import urfec_pkg::*;

  // no request beat while a result is held back
  `URFEC_ASSERT_NOW(a_no_accept_on_stall, clk, rst, in_valid && in_ready, !out_valid || out_ready)

  // a pop result never acknowledges error flags
  `URFEC_ASSERT_NOW(a_pop_no_mask, clk, rst, out_valid && pop_valid, clear_mask == '0)

  // a stalled result keeps its beat
  `URFEC_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({pop_valid, pop_byte, fill_count, clear_mask, parity_errors, framing_errors, noise_errors, overrun_errors, ring_overflows}))

  // nothing leaves right after reset
  `URFEC_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

endmodule

bind uart_rx_fifo_error_counters_core urfec_checker u_urfec_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .pop_valid      (rsp.pop_valid),
  .pop_byte       (rsp.pop_byte),
  .fill_count     (rsp.fill_count),
  .clear_mask     (rsp.clear_mask),
  .parity_errors  (rsp.parity_errors),
  .framing_errors (rsp.framing_errors),
  .noise_errors   (rsp.noise_errors),
  .overrun_errors (rsp.overrun_errors),
  .ring_overflows (rsp.ring_overflows)
);

`default_nettype wire
